>>> rtl/fail_bit_gather_packer_macros.svh
// Assertion macros for the fail-bit gather packer.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef FAIL_BIT_GATHER_PACKER_MACROS_SVH
`define FAIL_BIT_GATHER_PACKER_MACROS_SVH

`ifndef NO_ASSERTIONS

// check that holds outside reset
`define FBGP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that holds at every edge, reset included
`define FBGP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FBGP_ASSERT(label, clk, rst, prop, msg)
`define FBGP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> rtl/fbgp_pkg.sv
// Shared types and constants for the fail-bit gather packer.
// No dependencies; imported by every module of the block.
package fbgp_pkg;

   // io width modes
   localparam logic [1:0] MODE_1IO  = 2'd0;
   localparam logic [1:0] MODE_4IO  = 2'd1;
   localparam logic [1:0] MODE_8IO  = 2'd2;
   localparam logic [1:0] MODE_16IO = 2'd3;

   // configuration register indexes
   localparam logic [2:0] CSR_IO_MODE    = 3'd0;
   localparam logic [2:0] CSR_DDR_ENABLE = 3'd1;
   localparam logic [2:0] CSR_IO0_BIT    = 3'd2;
   localparam logic [2:0] CSR_IO1_BIT    = 3'd3;
   localparam logic [2:0] CSR_IO2_BIT    = 3'd4;
   localparam logic [2:0] CSR_IO3_BIT    = 3'd5;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 3;

   typedef struct packed {
      logic [15:0] single_word;
      logic [15:0] dual_word;
      logic        run_last;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] packed_data;
      logic        result_last;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0]      io_mode;
      logic            ddr_enable;
      logic [3:0][2:0] io_bit;
   } cfg_type;

   // results and next pack state for one entry
   typedef struct packed {
      logic [1:0]                 count;
      rsp_payload_type [1:0]      rsp;
      logic [7:0]                 accum;
      logic [2:0]                 position;
   } pack_result_type;

   // response buffer status toward the input stage
   typedef struct packed {
      logic       free;
      logic [1:0] count;
   } buf_status_type;

endpackage

>>> rtl/fbgp_pack_logic.sv
// Combinational packing of one fail-memory entry into up to two results.
// Depends on fbgp_pkg for payload, config and result types.
module fbgp_pack_logic
   import fbgp_pkg::*;
(
   input  cfg_type         cfg,
   input  req_payload_type item,
   input  logic [7:0]      accum,
   input  logic [2:0]      position,
   output pack_result_type result
);

   typedef struct packed {
      logic [7:0] accum;
      logic [2:0] position;
      logic       emit;
      logic [7:0] emit_value;
   } group_type;

   // place one group of bits at the current position, emit on a full byte
   function automatic group_type pack_group(input logic [7:0] acc, input logic [2:0] pos,
                                            input logic [3:0] g, input logic wide);
      group_type   r;
      logic [11:0] shifted;
      logic [3:0]  pos_sum;
      logic [7:0]  acc_new;
      shifted = {8'b0, g} << pos;
      acc_new = acc | shifted[7:0];
      pos_sum = {1'b0, pos} + (wide ? 4'd4 : 4'd1);
      r.emit_value = acc_new;
      if (pos_sum >= 4'd8) begin
         r.emit     = 1'b1;
         r.accum    = 8'd0;
         r.position = 3'd0;
      end else begin
         r.emit     = 1'b0;
         r.accum    = acc_new;
         r.position = pos_sum[2:0];
      end
      return r;
   endfunction

   // pick device io bits out of the low byte of a word
   function automatic logic [3:0] gather(input logic [7:0] word, input cfg_type c,
                                         input logic wide);
      logic [3:0] g;
      for (int i = 0; i < 4; i++) begin
         g[i] = word[c.io_bit[i]];
      end
      return wide ? g : {3'b0, g[0]};
   endfunction

   logic       wide;
   logic       bit_mode;
   group_type  grp_single;
   group_type  grp_dual;
   logic [7:0] acc_mid;
   logic [2:0] pos_mid;
   logic [15:0] word_mask;

   assign wide     = (cfg.io_mode == MODE_4IO);
   assign bit_mode = (cfg.io_mode == MODE_1IO) || (cfg.io_mode == MODE_4IO);
   assign word_mask = (cfg.io_mode == MODE_16IO) ? 16'hffff : 16'h00ff;

   // two chained groups: single-rate word, then dual-rate word
   assign grp_single = pack_group(accum, position, gather(item.single_word[7:0], cfg, wide),
                                  wide);
   assign grp_dual   = pack_group(grp_single.accum, grp_single.position,
                                  gather(item.dual_word[7:0], cfg, wide), wide);

   // collect emitted values in order and the next pack state
   always_comb begin
      result = '0;
      acc_mid = grp_single.accum;
      pos_mid = grp_single.position;
      if (bit_mode) begin
         if (grp_single.emit) begin
            result.rsp[result.count[0]].packed_data = {8'b0, grp_single.emit_value};
            result.count = result.count + 2'd1;
         end
         if (cfg.ddr_enable) begin
            if (grp_dual.emit) begin
               result.rsp[result.count[0]].packed_data = {8'b0, grp_dual.emit_value};
               result.count = result.count + 2'd1;
            end
            acc_mid = grp_dual.accum;
            pos_mid = grp_dual.position;
         end
         result.accum    = acc_mid;
         result.position = pos_mid;
         // flush a partial byte at run end
         if (item.run_last) begin
            if (pos_mid != 3'd0) begin
               result.rsp[result.count[0]].packed_data = {8'b0, acc_mid};
               result.count = result.count + 2'd1;
            end
            result.accum    = 8'd0;
            result.position = 3'd0;
         end
      end else begin
         result.rsp[0].packed_data = item.single_word & word_mask;
         result.count = 2'd1;
         if (cfg.ddr_enable) begin
            result.rsp[1].packed_data = item.dual_word & word_mask;
            result.count = 2'd2;
         end
         result.accum    = item.run_last ? 8'd0 : accum;
         result.position = item.run_last ? 3'd0 : position;
      end
      // mark the final result of this entry
      result.rsp[0].result_last = (result.count == 2'd1);
      result.rsp[1].result_last = 1'b1;
   end

endmodule

>>> rtl/fbgp_rsp_buffer.sv
// Two-slot response buffer that drains one result per transaction.
// Depends on fbgp_pkg and the assertion macros header.
`include "fail_bit_gather_packer_macros.svh"

module fbgp_rsp_buffer
   import fbgp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  pack_result_type load_data,
   output buf_status_type  status,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   logic [1:0]      cnt_ff, cnt_in;
   rsp_payload_type slot0_ff, slot0_in;
   rsp_payload_type slot1_ff, slot1_in;
   logic            take;
   logic [1:0]      cnt_after;

   assign take      = (cnt_ff != 2'd0) && !rsp_stall;
   assign cnt_after = cnt_ff - {1'b0, take};

   assign status.free  = (cnt_after == 2'd0);
   assign status.count = cnt_ff;

   // drain head, shift second slot forward, or load a new pair
   always_comb begin
      cnt_in   = cnt_after;
      slot0_in = take ? slot1_ff : slot0_ff;
      slot1_in = slot1_ff;
      if (load) begin
         cnt_in   = load_data.count;
         slot0_in = load_data.rsp[0];
         slot1_in = load_data.rsp[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_valid   = (cnt_ff != 2'd0);
   assign rsp_payload = slot0_ff;

   `FBGP_ASSERT(a_cnt_range, clock, reset, (cnt_ff != 2'd3), "response count out of range")
   `FBGP_ASSERT(a_load_empty, clock, reset, (load |-> cnt_after == 2'd0), "load over live data")
   `FBGP_ASSERT(a_load_count, clock, reset, (load |=> cnt_ff == $past(load_data.count)),
      "loaded count not held")

endmodule

>>> rtl/fail_bit_gather_packer.sv
// Fail-bit gather packer top level: config registers, input register, pack state.
// Depends on fbgp_pkg, fbgp_pack_logic, fbgp_rsp_buffer and the macros header.
//
//   channel   ports                                   direction
//   req       req_valid, req_stall, req_payload       in  (entry transaction)
//   rsp       rsp_valid, rsp_stall, rsp_payload       out (packed result)
//   csr       csr_we, csr_index, csr_wdata            in  (register write)
//
// An entry enters the input register, is packed in the next cycle into up to two
// results, and these leave the two-slot response buffer one per cycle.
// Sustained rate: one entry per cycle while each yields at most one result and rsp
// is not stalled; a two-result entry (DDR on) holds the next on the single rsp port.
// Synchronous active-high reset clears pack state, valids and config to defaults.
// A stall on rsp holds the buffer; an entry with results waits in the input register
// until the buffer empties, and req_stall follows.
`include "fail_bit_gather_packer_macros.svh"

module fail_bit_gather_packer
   import fbgp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type         cfg_ff, cfg_in;
   logic            in_valid_ff, in_valid_in;
   req_payload_type in_data_ff;
   logic [7:0]      accum_ff, accum_in;
   logic [2:0]      position_ff, position_in;
   pack_result_type pack;
   buf_status_type  buf_status;
   logic            advance;
   logic            in_load;

   // configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IO_MODE:    cfg_in.io_mode    = csr_wdata[1:0];
            CSR_DDR_ENABLE: cfg_in.ddr_enable = csr_wdata[0];
            CSR_IO0_BIT:    cfg_in.io_bit[0]  = csr_wdata;
            CSR_IO1_BIT:    cfg_in.io_bit[1]  = csr_wdata;
            CSR_IO2_BIT:    cfg_in.io_bit[2]  = csr_wdata;
            CSR_IO3_BIT:    cfg_in.io_bit[3]  = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // pack one entry from the input register
   fbgp_pack_logic u_pack (
      .cfg      (cfg_ff),
      .item     (in_data_ff),
      .accum    (accum_ff),
      .position (position_ff),
      .result   (pack)
   );

   // entry moves on once the buffer can take its results
   assign advance   = in_valid_ff && ((pack.count == 2'd0) || buf_status.free);
   assign req_stall = in_valid_ff && !advance;
   assign in_load   = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_load ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      accum_in    = advance ? pack.accum : accum_ff;
      position_in = advance ? pack.position : position_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.io_mode    <= MODE_8IO;
         cfg_ff.ddr_enable <= 1'b0;
         cfg_ff.io_bit[0]  <= 3'd0;
         cfg_ff.io_bit[1]  <= 3'd1;
         cfg_ff.io_bit[2]  <= 3'd2;
         cfg_ff.io_bit[3]  <= 3'd3;
         in_valid_ff       <= 1'b0;
         accum_ff          <= 8'd0;
         position_ff       <= 3'd0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
         accum_ff    <= accum_in;
         position_ff <= position_in;
      end
      if (in_load) begin
         in_data_ff <= req_payload;
      end
   end

   // response buffer
   fbgp_rsp_buffer u_rsp_buffer (
      .clock       (clock),
      .reset       (reset),
      .load        (advance && (pack.count != 2'd0)),
      .load_data   (pack),
      .status      (buf_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   `FBGP_ASSERT(a_stall_needs_entry, clock, reset, (req_stall |-> in_valid_ff),
      "stall without a waiting entry")
   `FBGP_ASSERT(a_byte_modes_emit, clock, reset,
      ((in_valid_ff && (cfg_ff.io_mode == MODE_8IO || cfg_ff.io_mode == MODE_16IO))
       |-> pack.count != 2'd0), "byte or word mode entry without result")
   `FBGP_ASSERT(a_state_hold, clock, reset,
      (!$past(advance) |-> ($stable(accum_ff) && $stable(position_ff))),
      "pack state changed without an entry")

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the fail-bit gather packer: directed and random entry traffic.
// Depends on fbgp_pkg and the fail_bit_gather_packer top level; predicts packed results
// internally.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fbgp_pkg::*;

   localparam int HOLD_OFF    = 6;
   localparam int QUIET_LIMIT = 4000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // register copy and byte-packing state, at their reset values
   logic [1:0]      cfg_mode = MODE_8IO;
   logic            cfg_ddr = 1'b0;
   logic [2:0]      cfg_io_bit [4] = '{3'd0, 3'd1, 3'd2, 3'd3};
   logic [7:0]      fail_byte = '0;
   logic [3:0]      fail_fill = '0;

   rsp_payload_type entry_results [$];
   rsp_payload_type expected_packs [$];
   rsp_payload_type oldest_pack;

   int mismatch_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int quiet_cycles = 0;

   fail_bit_gather_packer i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   // pick the configured io bits out of the low byte
   function automatic logic [3:0] gather_io_bits(logic [7:0] entry_byte, int width);
      logic [3:0] bits;
      bits = '0;
      for (int i = 0; i < width; i++) bits[i] = entry_byte[cfg_io_bit[i]];
      return bits;
   endfunction

   // place one group into the fail byte, emit when it fills
   function automatic void place_group(logic [7:0] entry_byte, int width);
      logic [11:0] shifted;
      shifted = {8'h00, gather_io_bits(entry_byte, width)} << fail_fill[2:0];
      fail_byte = fail_byte | shifted[7:0];
      fail_fill = fail_fill + 4'(width);
      if (fail_fill >= 4'd8) begin
         entry_results.push_back('{packed_data: {8'h00, fail_byte}, result_last: 1'b0});
         fail_byte = '0;
         fail_fill = '0;
      end
   endfunction

   // expected results of one accepted entry
   function automatic void pack_fail_entry(req_payload_type entry);
      rsp_payload_type item;
      entry_results.delete();
      if (cfg_mode == MODE_1IO || cfg_mode == MODE_4IO) begin
         place_group(entry.single_word[7:0], (cfg_mode == MODE_1IO) ? 1 : 4);
         if (cfg_ddr) place_group(entry.dual_word[7:0], (cfg_mode == MODE_1IO) ? 1 : 4);
         if (entry.run_last) begin
            // flush a partly filled byte
            if (fail_fill != 4'd0)
               entry_results.push_back('{packed_data: {8'h00, fail_byte}, result_last: 1'b0});
            fail_byte = '0;
            fail_fill = '0;
         end
      end else begin
         entry_results.push_back('{packed_data: (cfg_mode == MODE_16IO) ? entry.single_word :
                                   {8'h00, entry.single_word[7:0]}, result_last: 1'b0});
         if (cfg_ddr)
            entry_results.push_back('{packed_data: (cfg_mode == MODE_16IO) ? entry.dual_word :
                                      {8'h00, entry.dual_word[7:0]}, result_last: 1'b0});
         if (entry.run_last) begin
            fail_byte = '0;
            fail_fill = '0;
         end
      end
      foreach (entry_results[i]) begin
         item = entry_results[i];
         item.result_last = (i == entry_results.size() - 1);
         expected_packs.push_back(item);
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_packs.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual data %h last %b",
                     $time, rsp_payload.packed_data, rsp_payload.result_last);
            mismatch_count++;
         end else begin
            oldest_pack = expected_packs.pop_front();
            if (rsp_payload.packed_data !== oldest_pack.packed_data) begin
               $display("%0t: packed_data mismatch: expected %h actual %h",
                        $time, oldest_pack.packed_data, rsp_payload.packed_data);
               mismatch_count++;
            end
            if (rsp_payload.result_last !== oldest_pack.result_last) begin
               $display("%0t: result_last mismatch: expected %b actual %b",
                        $time, oldest_pack.result_last, rsp_payload.result_last);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one register write, copied into the prediction at the write edge
   task automatic csr_write(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         CSR_IO_MODE:    cfg_mode = value[1:0];
         CSR_DDR_ENABLE: cfg_ddr = value[0];
         CSR_IO0_BIT:    cfg_io_bit[0] = value;
         CSR_IO1_BIT:    cfg_io_bit[1] = value;
         CSR_IO2_BIT:    cfg_io_bit[2] = value;
         CSR_IO3_BIT:    cfg_io_bit[3] = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(logic [1:0] mode, logic ddr, logic [2:0] b0, logic [2:0] b1,
                             logic [2:0] b2, logic [2:0] b3);
      csr_write(CSR_IO_MODE, {1'b0, mode});
      csr_write(CSR_DDR_ENABLE, {2'b00, ddr});
      csr_write(CSR_IO0_BIT, b0);
      csr_write(CSR_IO1_BIT, b1);
      csr_write(CSR_IO2_BIT, b2);
      csr_write(CSR_IO3_BIT, b3);
   endtask

   // send one entry transaction, with random idle cycles ahead of it
   task automatic send_entry(logic [15:0] single_word, logic [15:0] dual_word, logic run_last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{single_word: single_word, dual_word: dual_word, run_last: run_last};
      do @(posedge clock); while (req_stall);
      pack_fail_entry(req_payload);
   endtask

   // stop sending until every expected result is out
   task automatic pause_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_packs.size() != 0) @(posedge clock);
   endtask

   // idle point for register writes: drained, then held off for entries with no result
   task automatic quiesce();
      pause_until_drained();
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   function automatic logic [15:0] random_word();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // reset values: 8 io, no ddr
   task automatic test_default_passthrough();
      send_entry(16'h0000, 16'hffff, 1'b0);
      send_entry(16'hffff, 16'h0000, 1'b1);
      send_entry(16'ha5c3, 16'h5a3c, 1'b0);
   endtask

   task automatic test_word_mode_ddr();
      quiesce();
      set_config(MODE_16IO, 1'b1, 3'd7, 3'd0, 3'd7, 3'd0);
      send_entry(16'hffff, 16'h0000, 1'b0);
      send_entry(16'h1234, 16'hfedc, 1'b1);
   endtask

   // single bit per word, byte closing on a run end, then a partial flush
   task automatic test_one_io_pack();
      quiesce();
      set_config(MODE_1IO, 1'b1, 3'd7, 3'd0, 3'd0, 3'd0);
      send_entry(16'h0080, 16'h0000, 1'b0);
      send_entry(16'hff7f, 16'h0080, 1'b0);
      send_entry(16'h0080, 16'h0080, 1'b0);
      send_entry(16'h0000, 16'hffff, 1'b1);
      send_entry(16'h0080, 16'h0000, 1'b1);
   endtask

   task automatic test_four_io_pack();
      quiesce();
      set_config(MODE_4IO, 1'b0, 3'd7, 3'd0, 3'd5, 3'd2);
      send_entry(16'h00a5, 16'hffff, 1'b0);
      send_entry(16'hff7e, 16'h0000, 1'b0);
      send_entry(16'h0081, 16'hffff, 1'b1);
   endtask

   // nibble starting above bit 4 after a mode change inside a run
   task automatic test_nibble_crossing();
      quiesce();
      set_config(MODE_1IO, 1'b1, 3'd3, 3'd1, 3'd2, 3'd0);
      send_entry(16'h0008, 16'h0000, 1'b0);
      send_entry(16'h0000, 16'h0008, 1'b0);
      send_entry(16'h0008, 16'h0008, 1'b0);
      quiesce();
      csr_write(CSR_IO_MODE, {1'b0, MODE_4IO});
      csr_write(CSR_DDR_ENABLE, 3'd0);
      send_entry(16'h00ff, 16'hffff, 1'b1);
   endtask

   // run end in a wide mode clears a partial byte without emitting it
   task automatic test_wide_run_end();
      quiesce();
      set_config(MODE_1IO, 1'b0, 3'd0, 3'd1, 3'd2, 3'd3);
      send_entry(16'h0001, 16'h0000, 1'b0);
      quiesce();
      csr_write(CSR_IO_MODE, {1'b0, MODE_8IO});
      send_entry(16'hffff, 16'hffff, 1'b1);
      quiesce();
      csr_write(CSR_IO_MODE, {1'b0, MODE_1IO});
      send_entry(16'h0001, 16'h0000, 1'b1);
   endtask

   // runs of random entries, mostly ended properly, with random settings between them
   task automatic test_random_runs(int entry_total, int sender_pct, int receiver_pct);
      int sent;
      int run_len;
      int run_kind;
      logic run_last;
      sent = 0;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      while (sent < entry_total) begin
         run_len  = $urandom_range(1, 24);
         run_kind = $urandom_range(9);
         if ($urandom_range(2) == 0) begin
            quiesce();
            set_config(2'($urandom_range(3)), 1'($urandom_range(1)),
                       3'($urandom_range(7)), 3'($urandom_range(7)),
                       3'($urandom_range(7)), 3'($urandom_range(7)));
         end
         for (int i = 0; i < run_len; i++) begin
            // open runs and early run ends are the broken cases
            if (i == run_len - 1) run_last = (run_kind != 0);
            else run_last = (run_kind == 1) && ($urandom_range(5) == 0);
            send_entry(random_word(), random_word(), run_last);
            if ($urandom_range(149) == 0) pause_until_drained();
         end
         sent += run_len;
      end
      quiesce();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_default_passthrough();
      test_word_mode_ddr();
      test_one_io_pack();
      test_four_io_pack();
      test_nibble_crossing();
      test_wide_run_end();
      test_random_runs(630, 38, 65);
      test_random_runs(630, 65, 38);
      test_random_runs(640, 0, 0);

      quiesce();
      if (mismatch_count == 0 && expected_packs.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/fbgp_pkg.sv
rtl/fbgp_pack_logic.sv
rtl/fbgp_rsp_buffer.sv
rtl/fail_bit_gather_packer.sv
tb/sv/tb_top.sv
